// ----- hdl/rope_distance_constraint_solver_assert.svh -----
// Assertion macros shared by the rope solver RTL.
// Each macro samples on the rising edge of aclk and is inactive while aresetn is low.
`ifndef ROPE_DISTANCE_CONSTRAINT_SOLVER_ASSERT_SVH
`define ROPE_DISTANCE_CONSTRAINT_SOLVER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RDCS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RDCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/rdcs_pkg.sv -----
package rdcs_pkg;

    // Chain storage and field widths.
    localparam int MAX_LINKS = 64;
    localparam int IDX_W     = 6;
    localparam int CNT_W     = 7;
    localparam int POS_W     = 24;
    localparam int ANG_W     = 14;
    localparam int REST_W    = 16;
    localparam int PASS_W    = 4;
    localparam int CFG_A_W   = 2;
    localparam int CFG_D_W   = 16;

    // Internal datapath widths.
    localparam int DIF_W  = POS_W + 1;
    localparam int RAD_W  = 2 * DIF_W;
    localparam int ROOT_W = DIF_W;
    localparam int ERR_W  = ROOT_W + 1;
    localparam int DVD_W  = DIF_W + ERR_W;
    localparam int Q_W    = ERR_W;
    localparam int CW     = 48;
    localparam int ZW     = 19;
    localparam int CORDIC_STEPS    = 16;
    localparam int CORDIC_PRESCALE = 20;

    localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;
    localparam logic signed [POS_W-1:0] POS_MIN = -24'sh800000;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q12 = 14'sd6434;
    localparam logic signed [ZW-1:0]    HALF_PI_Q16 = 19'sd102944;

    // Reset values of the configuration registers.
    localparam logic [CNT_W-1:0]  LINK_COUNT_RST = 7'd16;
    localparam logic [REST_W-1:0] REST_LEN_RST   = 16'd2560;
    localparam logic [PASS_W-1:0] PASS_COUNT_RST = 4'd10;

    // Configuration register indexes.
    localparam logic [CFG_A_W-1:0] CFG_LINK_COUNT  = 2'd0;
    localparam logic [CFG_A_W-1:0] CFG_REST_LENGTH = 2'd1;
    localparam logic [CFG_A_W-1:0] CFG_PASS_COUNT  = 2'd2;

    // Request types.
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_SOLVE = 1'b1;

    typedef enum logic [14:0] {
        ST_IDLE    = 15'b000000000000001,
        ST_RD0     = 15'b000000000000010,
        ST_RD1     = 15'b000000000000100,
        ST_CAP     = 15'b000000000001000,
        ST_SQX     = 15'b000000000010000,
        ST_SQY     = 15'b000000000100000,
        ST_SQRT    = 15'b000000001000000,
        ST_CORD    = 15'b000000010000000,
        ST_MULX    = 15'b000000100000000,
        ST_DIVX    = 15'b000001000000000,
        ST_MULY    = 15'b000010000000000,
        ST_DIVY    = 15'b000100000000000,
        ST_WR      = 15'b001000000000000,
        ST_OUT_RD  = 15'b010000000000000,
        ST_OUT_CAP = 15'b100000000000000
    } state_t;

    // Arctangent of 2^-i in Q0.16.
    function automatic logic signed [ZW-1:0] atan_lut(input logic [3:0] i);
        logic signed [ZW-1:0] v;
        case (i)
            4'd0:  v = 19'sd51472;
            4'd1:  v = 19'sd30385;
            4'd2:  v = 19'sd16055;
            4'd3:  v = 19'sd8150;
            4'd4:  v = 19'sd4091;
            4'd5:  v = 19'sd2047;
            4'd6:  v = 19'sd1024;
            4'd7:  v = 19'sd512;
            4'd8:  v = 19'sd256;
            4'd9:  v = 19'sd128;
            4'd10: v = 19'sd64;
            4'd11: v = 19'sd32;
            4'd12: v = 19'sd16;
            4'd13: v = 19'sd8;
            4'd14: v = 19'sd4;
            default: v = 19'sd2;
        endcase
        return v;
    endfunction

endpackage

// ----- hdl/rdcs_ram.sv -----
module rdcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port; read data holds when idle.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hdl/rope_distance_constraint_solver.sv -----
// Rope distance-constraint solver.
// Input channel (s_*): a load request writes one link position (s_link_index, s_pos_x,
// s_pos_y). A solve request pins link 0 to (s_pos_x, s_pos_y), runs pass_count relaxation
// passes over the link pairs, and then emits one result per link on the m_* channel in
// index order, with m_last on the final link.
// Configuration (cfg_*): register writes are always accepted; write only while idle.
// Each pair visit steps through the reads, two squares, a 25-step square root, a 16-step
// CORDIC, two 51-step restoring divisions with a set-up state each, and one write-back;
// a pair at zero distance exits after the square root. When the passes are done, each
// result is read from the link store and then captured into the output register.
// Input requests are taken only while the solver is idle; a load in the idle state is
// taken every cycle. When the receiver stalls, the result holds in the output register
// and the solver holds the next link it has read until the register frees.
// Reset clears the link store to zero through per-entry valid bits, restores the
// configuration defaults (16 links, rest length 2560, 10 passes), and idles.
module rope_distance_constraint_solver (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_valid,
    output logic                                      s_ready,
    input  logic                                      s_req_type,
    input  logic [rdcs_pkg::IDX_W-1:0]                s_link_index,
    input  logic signed [rdcs_pkg::POS_W-1:0]         s_pos_x,
    input  logic signed [rdcs_pkg::POS_W-1:0]         s_pos_y,
    output logic                                      m_valid,
    input  logic                                      m_ready,
    output logic [rdcs_pkg::IDX_W-1:0]                m_out_index,
    output logic signed [rdcs_pkg::POS_W-1:0]         m_out_x,
    output logic signed [rdcs_pkg::POS_W-1:0]         m_out_y,
    output logic signed [rdcs_pkg::ANG_W-1:0]         m_out_angle,
    output logic                                      m_last,
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [rdcs_pkg::CFG_A_W-1:0]              cfg_addr,
    input  logic [rdcs_pkg::CFG_D_W-1:0]              cfg_data
);

    import rdcs_pkg::*;

    `include "rope_distance_constraint_solver_assert.svh"

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  link_count_reg, link_count_next;
    logic [REST_W-1:0] rest_len_reg, rest_len_next;
    logic [PASS_W-1:0] pass_count_reg, pass_count_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [PASS_W-1:0] pass_reg, pass_next;
    logic [IDX_W-1:0]  pair_reg, pair_next;
    logic [IDX_W-1:0]  out_idx_reg, out_idx_next;
    logic [5:0]        iter_reg, iter_next;

    logic signed [POS_W-1:0] x0_reg, x0_next, y0_reg, y0_next;
    logic signed [POS_W-1:0] x1_reg, x1_next, y1_reg, y1_next;
    logic signed [POS_W-1:0] nx_reg, nx_next, ny_reg, ny_next;
    logic signed [DIF_W-1:0] dx_reg, dx_next, dy_reg, dy_next;

    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [ROOT_W:0]   srem_reg, srem_next;
    logic [ROOT_W-1:0] root_reg, root_next;

    logic signed [CW-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [ZW-1:0] cz_reg, cz_next;

    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [ROOT_W-1:0] drem_reg, drem_next;
    logic [Q_W-1:0]    q_reg, q_next;
    logic              qneg_reg, qneg_next;

    logic                    m_valid_reg, m_valid_next;
    logic [IDX_W-1:0]        m_index_reg, m_index_next;
    logic signed [POS_W-1:0] m_x_reg, m_x_next, m_y_reg, m_y_next;
    logic signed [ANG_W-1:0] m_angle_reg, m_angle_next;
    logic                    m_last_reg, m_last_next;

    logic [MAX_LINKS-1:0] pos_vld_reg, pos_vld_next;
    logic [MAX_LINKS-1:0] ang_vld_reg, ang_vld_next;
    logic                 rvld_pos_reg, rvld_ang_reg;

    // Memory ports.
    logic                    pos_we, ang_we, mem_re;
    logic [IDX_W-1:0]        pos_waddr, ang_waddr, mem_raddr;
    logic [2*POS_W-1:0]      pos_wdata, pos_rdata, pos_rd;
    logic [ANG_W-1:0]        ang_wdata, ang_rdata, ang_rd;

    rdcs_ram #(.WIDTH(2*POS_W), .DEPTH(MAX_LINKS)) u_pos_ram (
        .aclk  (aclk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (pos_rdata)
    );

    rdcs_ram #(.WIDTH(ANG_W), .DEPTH(MAX_LINKS)) u_ang_ram (
        .aclk  (aclk),
        .we    (ang_we),
        .waddr (ang_waddr),
        .wdata (ang_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (ang_rdata)
    );

    // Entries never written read as zero.
    assign pos_rd = rvld_pos_reg ? pos_rdata : '0;
    assign ang_rd = rvld_ang_reg ? ang_rdata : '0;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    assign m_valid     = m_valid_reg;
    assign m_out_index = m_index_reg;
    assign m_out_x     = m_x_reg;
    assign m_out_y     = m_y_reg;
    assign m_out_angle = m_angle_reg;
    assign m_last      = m_last_reg;

    logic s_fire;
    assign s_fire = s_valid && s_ready;

    // Pair magnitudes and the length error.
    logic [DIF_W-1:0]        dx_mag, dy_mag;
    logic signed [ERR_W-1:0] err_c;
    assign dx_mag = dx_reg[DIF_W-1] ? DIF_W'(-dx_reg) : DIF_W'(dx_reg);
    assign dy_mag = dy_reg[DIF_W-1] ? DIF_W'(-dy_reg) : DIF_W'(dy_reg);
    assign err_c  = $signed({1'b0, root_reg}) - $signed({{(ERR_W-REST_W){1'b0}}, rest_len_reg});

    // One square per cycle.
    logic [RAD_W-1:0] sq_c;
    assign sq_c = (state_reg == ST_SQX) ? dx_mag * dx_mag : dy_mag * dy_mag;

    // Square root digit step.
    logic [ROOT_W+2:0] s_sh, s_trial;
    logic              s_ge;
    logic [ROOT_W-1:0] root_step;
    assign s_sh      = {srem_reg, rad_reg[RAD_W-1 -: 2]};
    assign s_trial   = {1'b0, root_reg, 2'b01};
    assign s_ge      = (s_sh >= s_trial);
    assign root_step = {root_reg[ROOT_W-2:0], s_ge};

    // CORDIC rotation step.
    logic signed [CW-1:0] cxs, cys;
    logic signed [ZW-1:0] atan_c;
    assign cxs    = cx_reg >>> iter_reg[3:0];
    assign cys    = cy_reg >>> iter_reg[3:0];
    assign atan_c = atan_lut(iter_reg[3:0]);

    // Move numerator: coordinate difference times the error.
    logic signed [DVD_W-1:0] prod_c;
    logic [DVD_W-1:0]        prod_mag;
    assign prod_c   = ((state_reg == ST_MULX) ? dx_reg : dy_reg) * err_c;
    assign prod_mag = prod_c[DVD_W-1] ? DVD_W'(-prod_c) : DVD_W'(prod_c);

    // Restoring division step.
    logic [ROOT_W:0]   d_sh;
    logic              d_ge;
    logic [Q_W-1:0]    q_step;
    assign d_sh   = {drem_reg, dvd_reg[DVD_W-1]};
    assign d_ge   = (d_sh >= {1'b0, root_reg});
    assign q_step = {q_reg[Q_W-2:0], d_ge};

    // Moved coordinate with saturation.
    logic signed [Q_W:0]     q_sig;
    logic signed [POS_W-1:0] base_c;
    logic signed [POS_W+3:0] new_c;
    logic signed [POS_W-1:0] new_sat;
    assign q_sig  = qneg_reg ? -$signed({1'b0, q_step}) : $signed({1'b0, q_step});
    assign base_c = (state_reg == ST_DIVX) ? x1_reg : y1_reg;
    assign new_c  = (POS_W+4)'(base_c) - (POS_W+4)'(q_sig);
    always_comb begin
        if (new_c > (POS_W+4)'(POS_MAX)) begin
            new_sat = POS_MAX;
        end else if (new_c < (POS_W+4)'(POS_MIN)) begin
            new_sat = POS_MIN;
        end else begin
            new_sat = new_c[POS_W-1:0];
        end
    end

    // Pair angle from the CORDIC accumulator.
    logic [16:0]             zc;
    logic [12:0]             amag;
    logic signed [ANG_W-1:0] angle_c;
    always_comb begin
        if (cz_reg < 0) begin
            zc = '0;
        end else if (cz_reg > HALF_PI_Q16) begin
            zc = HALF_PI_Q16[16:0];
        end else begin
            zc = cz_reg[16:0];
        end
        amag = 13'((18'(zc) + 18'd8) >> 4);
        if (amag > HALF_PI_Q12[12:0]) begin
            amag = HALF_PI_Q12[12:0];
        end
        if (dy_reg == '0) begin
            angle_c = '0;
        end else if (dx_reg == '0) begin
            angle_c = dy_reg[DIF_W-1] ? -HALF_PI_Q12 : HALF_PI_Q12;
        end else if (dx_reg[DIF_W-1] != dy_reg[DIF_W-1]) begin
            angle_c = -$signed({1'b0, amag});
        end else begin
            angle_c = $signed({1'b0, amag});
        end
    end

    logic pair_last, pass_last, out_last, out_free;
    assign pair_last = ({1'b0, pair_reg} + CNT_W'(2) == n_reg);
    assign pass_last = ({1'b0, pass_reg} + 5'd1 == {1'b0, pass_count_reg});
    assign out_last  = ({1'b0, out_idx_reg} + CNT_W'(1) == n_reg);
    assign out_free  = !m_valid_reg || m_ready;

    // Sequencer and datapath next state.
    always_comb begin
        state_next      = state_reg;
        link_count_next = link_count_reg;
        rest_len_next   = rest_len_reg;
        pass_count_next = pass_count_reg;
        n_next          = n_reg;
        pass_next       = pass_reg;
        pair_next       = pair_reg;
        out_idx_next    = out_idx_reg;
        iter_next       = iter_reg;
        x0_next = x0_reg;  y0_next = y0_reg;
        x1_next = x1_reg;  y1_next = y1_reg;
        nx_next = nx_reg;  ny_next = ny_reg;
        dx_next = dx_reg;  dy_next = dy_reg;
        rad_next  = rad_reg;
        srem_next = srem_reg;
        root_next = root_reg;
        cx_next = cx_reg;  cy_next = cy_reg;  cz_next = cz_reg;
        dvd_next  = dvd_reg;
        drem_next = drem_reg;
        q_next    = q_reg;
        qneg_next = qneg_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_index_next = m_index_reg;
        m_x_next     = m_x_reg;
        m_y_next     = m_y_reg;
        m_angle_next = m_angle_reg;
        m_last_next  = m_last_reg;
        pos_vld_next = pos_vld_reg;
        ang_vld_next = ang_vld_reg;
        pos_we    = 1'b0;
        pos_waddr = pair_reg + IDX_W'(1);
        pos_wdata = {nx_reg, ny_reg};
        ang_we    = 1'b0;
        ang_waddr = pair_reg + IDX_W'(1);
        ang_wdata = angle_c;
        mem_re    = 1'b0;
        mem_raddr = pair_reg;

        // Configuration writes.
        if (cfg_valid && cfg_ready) begin
            case (cfg_addr)
                CFG_LINK_COUNT:  link_count_next = cfg_data[CNT_W-1:0];
                CFG_REST_LENGTH: rest_len_next   = cfg_data[REST_W-1:0];
                CFG_PASS_COUNT:  pass_count_next = cfg_data[PASS_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    pos_we    = 1'b1;
                    pos_wdata = {s_pos_x, s_pos_y};
                    if (s_req_type == REQ_LOAD) begin
                        pos_waddr = s_link_index;
                        pos_vld_next[s_link_index] = 1'b1;
                    end else begin
                        pos_waddr       = '0;
                        pos_vld_next[0] = 1'b1;
                        if (link_count_reg < CNT_W'(2)) begin
                            n_next = CNT_W'(2);
                        end else if (link_count_reg > CNT_W'(MAX_LINKS)) begin
                            n_next = CNT_W'(MAX_LINKS);
                        end else begin
                            n_next = link_count_reg;
                        end
                        pass_next    = '0;
                        pair_next    = '0;
                        out_idx_next = '0;
                        state_next   = (pass_count_reg == '0) ? ST_OUT_RD : ST_RD0;
                    end
                end
            end
            ST_RD0: begin
                mem_re     = 1'b1;
                mem_raddr  = pair_reg;
                state_next = ST_RD1;
            end
            ST_RD1: begin
                mem_re     = 1'b1;
                mem_raddr  = pair_reg + IDX_W'(1);
                x0_next    = pos_rd[2*POS_W-1 -: POS_W];
                y0_next    = pos_rd[POS_W-1:0];
                state_next = ST_CAP;
            end
            ST_CAP: begin
                x1_next    = pos_rd[2*POS_W-1 -: POS_W];
                y1_next    = pos_rd[POS_W-1:0];
                dx_next    = DIF_W'(x1_next) - DIF_W'(x0_reg);
                dy_next    = DIF_W'(y1_next) - DIF_W'(y0_reg);
                state_next = ST_SQX;
            end
            ST_SQX: begin
                rad_next   = sq_c;
                state_next = ST_SQY;
            end
            ST_SQY: begin
                rad_next   = rad_reg + sq_c;
                srem_next  = '0;
                root_next  = '0;
                iter_next  = '0;
                state_next = ST_SQRT;
            end
            ST_SQRT: begin
                rad_next  = rad_reg << 2;
                srem_next = s_ge ? (ROOT_W+1)'(s_sh - s_trial) : (ROOT_W+1)'(s_sh);
                root_next = root_step;
                iter_next = iter_reg + 6'd1;
                if (iter_reg == 6'(ROOT_W - 1)) begin
                    iter_next = '0;
                    cx_next   = CW'({dx_mag, {CORDIC_PRESCALE{1'b0}}});
                    cy_next   = CW'({dy_mag, {CORDIC_PRESCALE{1'b0}}});
                    cz_next   = '0;
                    if (root_step == '0) begin
                        // Coincident links: leave the pair untouched.
                        if (pair_last) begin
                            if (pass_last) begin
                                out_idx_next = '0;
                                state_next   = ST_OUT_RD;
                            end else begin
                                pass_next  = pass_reg + PASS_W'(1);
                                pair_next  = '0;
                                state_next = ST_RD0;
                            end
                        end else begin
                            pair_next  = pair_reg + IDX_W'(1);
                            state_next = ST_RD0;
                        end
                    end else begin
                        state_next = ST_CORD;
                    end
                end
            end
            ST_CORD: begin
                if (cy_reg > 0) begin
                    cx_next = cx_reg + cys;
                    cy_next = cy_reg - cxs;
                    cz_next = cz_reg + atan_c;
                end else begin
                    cx_next = cx_reg - cys;
                    cy_next = cy_reg + cxs;
                    cz_next = cz_reg - atan_c;
                end
                iter_next = iter_reg + 6'd1;
                if (iter_reg == 6'(CORDIC_STEPS - 1)) begin
                    state_next = ST_MULX;
                end
            end
            ST_MULX, ST_MULY: begin
                // Rounded to nearest, ties away from zero.
                dvd_next   = prod_mag + DVD_W'(root_reg >> 1);
                qneg_next  = prod_c[DVD_W-1];
                drem_next  = '0;
                q_next     = '0;
                iter_next  = '0;
                state_next = (state_reg == ST_MULX) ? ST_DIVX : ST_DIVY;
            end
            ST_DIVX, ST_DIVY: begin
                dvd_next  = dvd_reg << 1;
                drem_next = d_ge ? ROOT_W'(d_sh - {1'b0, root_reg}) : ROOT_W'(d_sh);
                q_next    = q_step;
                iter_next = iter_reg + 6'd1;
                if (iter_reg == 6'(DVD_W - 1)) begin
                    if (state_reg == ST_DIVX) begin
                        nx_next    = new_sat;
                        state_next = ST_MULY;
                    end else begin
                        ny_next    = new_sat;
                        state_next = ST_WR;
                    end
                end
            end
            ST_WR: begin
                pos_we = 1'b1;
                ang_we = 1'b1;
                pos_vld_next[pair_reg + IDX_W'(1)] = 1'b1;
                ang_vld_next[pair_reg + IDX_W'(1)] = 1'b1;
                if (pair_last) begin
                    if (pass_last) begin
                        out_idx_next = '0;
                        state_next   = ST_OUT_RD;
                    end else begin
                        pass_next  = pass_reg + PASS_W'(1);
                        pair_next  = '0;
                        state_next = ST_RD0;
                    end
                end else begin
                    pair_next  = pair_reg + IDX_W'(1);
                    state_next = ST_RD0;
                end
            end
            ST_OUT_RD: begin
                mem_re     = 1'b1;
                mem_raddr  = out_idx_reg;
                state_next = ST_OUT_CAP;
            end
            ST_OUT_CAP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_index_next = out_idx_reg;
                    m_x_next     = pos_rd[2*POS_W-1 -: POS_W];
                    m_y_next     = pos_rd[POS_W-1:0];
                    m_angle_next = ang_rd;
                    m_last_next  = out_last;
                    if (out_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        out_idx_next = out_idx_reg + IDX_W'(1);
                        state_next   = ST_OUT_RD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            link_count_reg <= LINK_COUNT_RST;
            rest_len_reg   <= REST_LEN_RST;
            pass_count_reg <= PASS_COUNT_RST;
            m_valid_reg    <= 1'b0;
            pos_vld_reg    <= '0;
            ang_vld_reg    <= '0;
            rvld_pos_reg   <= 1'b0;
            rvld_ang_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            link_count_reg <= link_count_next;
            rest_len_reg   <= rest_len_next;
            pass_count_reg <= pass_count_next;
            m_valid_reg    <= m_valid_next;
            pos_vld_reg    <= pos_vld_next;
            ang_vld_reg    <= ang_vld_next;
            if (mem_re) begin
                rvld_pos_reg <= pos_vld_reg[mem_raddr];
                rvld_ang_reg <= ang_vld_reg[mem_raddr];
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        n_reg       <= n_next;
        pass_reg    <= pass_next;
        pair_reg    <= pair_next;
        out_idx_reg <= out_idx_next;
        iter_reg    <= iter_next;
        x0_reg <= x0_next;  y0_reg <= y0_next;
        x1_reg <= x1_next;  y1_reg <= y1_next;
        nx_reg <= nx_next;  ny_reg <= ny_next;
        dx_reg <= dx_next;  dy_reg <= dy_next;
        rad_reg  <= rad_next;
        srem_reg <= srem_next;
        root_reg <= root_next;
        cx_reg <= cx_next;  cy_reg <= cy_next;  cz_reg <= cz_next;
        dvd_reg  <= dvd_next;
        drem_reg <= drem_next;
        q_reg    <= q_next;
        qneg_reg <= qneg_next;
        m_index_reg <= m_index_next;
        m_x_reg     <= m_x_next;
        m_y_reg     <= m_y_next;
        m_angle_reg <= m_angle_next;
        m_last_reg  <= m_last_next;
    end

    // The divider only runs on a nonzero distance.
    `RDCS_ASSERT_SAME(a_div_nonzero, (state_reg == ST_DIVX || state_reg == ST_DIVY), (root_reg != '0), "divide by zero distance")
    // A relaxation write never touches the anchor link.
    `RDCS_ASSERT_SAME(a_wr_not_anchor, (state_reg == ST_WR), (pos_waddr != '0), "relaxation wrote link 0")
    // A stalled result is not overwritten by the next captured link.
    `RDCS_ASSERT_NEXT(a_out_hold, (state_reg == ST_OUT_CAP && m_valid_reg && !m_ready), ($stable(m_index_reg) && $stable(m_x_reg)), "pending result overwritten")
    // Requests are only taken while no solve is running.
    `RDCS_ASSERT_SAME(a_in_idle, (s_valid && s_ready), (state_reg == ST_IDLE && pos_we), "request taken while busy")

endmodule
